@@ hdl/ppf_pkg.sv @@
// shared constants and types for the pairwise particle force block
package ppf_pkg;

    // register indexes on the configuration channel
    localparam logic [7:0] REG_WINDOW_WIDTH  = 8'd0;
    localparam logic [7:0] REG_WINDOW_HEIGHT = 8'd1;
    localparam logic [7:0] REG_MIN_DISTANCE  = 8'd2;
    localparam logic [7:0] REG_MAX_DIST_SQ   = 8'd3;

    // reset values of the registers
    localparam logic [11:0] RST_WINDOW_WIDTH  = 12'd1024;
    localparam logic [11:0] RST_WINDOW_HEIGHT = 12'd768;
    localparam logic [19:0] RST_MIN_DISTANCE  = 20'd7680;
    localparam logic [39:0] RST_MAX_DIST_SQ   = 40'd655360000;

    // divider geometry
    localparam int DIV_NW  = 56;
    localparam int DIV_DW  = 44;
    localparam int DIV_Q   = 25;
    localparam int DIV_LAT = DIV_Q + 1;

    // square root iterations, one result bit each
    localparam int SQ_N = 21;

    // pipeline positions of the sideband
    localparam int ST_D        = 3;
    localparam int ST_SQ_END   = ST_D + SQ_N;
    localparam int ST_E        = ST_SQ_END + 1;
    localparam int ST_F        = ST_E + 1;
    localparam int ST_DIV1_OUT = ST_F + DIV_LAT;
    localparam int ST_G        = ST_DIV1_OUT + 1;
    localparam int ST_H        = ST_G + 1;
    localparam int ST_DIV2_OUT = ST_H + DIV_LAT;
    localparam int SB_LAST     = ST_DIV2_OUT;

    // saturation bounds of the increments
    localparam logic [24:0] INC_POS_MAX = 25'd524287;
    localparam logic [24:0] INC_NEG_MAX = 25'd524288;

    // sideband that travels with each request
    typedef struct packed {
        logic               valid;
        logic               live;
        logic               sep;
        logic               negx;
        logic               negy;
        logic signed [21:0] dx;
        logic signed [21:0] dy;
        logic signed [19:0] force_in;
        logic        [20:0] d;
    } t_side;

endpackage

@@ hdl/ppf_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module ppf_div (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ppf_pkg::DIV_NW-1:0] i_num,
    input  logic [ppf_pkg::DIV_DW-1:0] i_den,
    output logic [ppf_pkg::DIV_Q-1:0]  o_quo,
    output logic                  o_ovf
);
    import ppf_pkg::*;

    logic [DIV_DW:0]   r_rem [0:DIV_Q];
    logic [DIV_Q-1:0]  r_low [0:DIV_Q];
    logic [DIV_Q-1:0]  r_q   [0:DIV_Q];
    logic [DIV_DW-1:0] r_den [0:DIV_Q];
    logic              r_ovf [0:DIV_Q];

    logic [DIV_DW:0]   n_rem [0:DIV_Q];
    logic [DIV_Q-1:0]  n_low [0:DIV_Q];
    logic [DIV_Q-1:0]  n_q   [0:DIV_Q];
    logic [DIV_DW-1:0] n_den [0:DIV_Q];
    logic              n_ovf [0:DIV_Q];

    // load stage and one shift-subtract per later stage
    always_comb begin
        logic [DIV_DW+1:0] trial;
        logic [DIV_DW:0]   hi;
        hi = {{(DIV_DW+1-(DIV_NW-DIV_Q)){1'b0}}, i_num[DIV_NW-1:DIV_Q]};
        n_rem[0] = hi;
        n_low[0] = i_num[DIV_Q-1:0];
        n_q[0]   = '0;
        n_den[0] = i_den;
        n_ovf[0] = (hi >= {1'b0, i_den});
        for (int k = 0; k < DIV_Q; k++) begin
            trial = {r_rem[k], r_low[k][DIV_Q-1]};
            n_den[k+1] = r_den[k];
            n_ovf[k+1] = r_ovf[k];
            n_low[k+1] = {r_low[k][DIV_Q-2:0], 1'b0};
            if (trial >= {2'b00, r_den[k]}) begin
                n_rem[k+1] = (DIV_DW+1)'(trial - {2'b00, r_den[k]});
                n_q[k+1]   = {r_q[k][DIV_Q-2:0], 1'b1};
            end else begin
                n_rem[k+1] = trial[DIV_DW:0];
                n_q[k+1]   = {r_q[k][DIV_Q-2:0], 1'b0};
            end
        end
    end

    // stage registers advance together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_low <= n_low;
            r_q   <= n_q;
            r_den <= n_den;
            r_ovf <= n_ovf;
        end
    end

    assign o_quo = r_q[DIV_Q];
    assign o_ovf = r_ovf[DIV_Q];

endmodule

@@ hdl/pairwise_particle_force.sv @@
// top level of the pairwise particle force pipeline
//
// Each request on the slave stream is one particle pair: both positions and
// the pair's attraction strength. The block wraps the offset to the nearest
// image on the toroidal window, takes the exact integer square root of the
// squared distance, applies the separation law below the minimum distance,
// and returns the velocity increment force * dx / d, force * dy / d,
// rounded and saturated, with in_range on tuser.
// Throughput is one pair per cycle while the receiver does not stall. The
// latency from acceptance to master tvalid is set by the 21-stage square
// root and two 26-stage dividers in series (separation, then increments).
// The configuration channel is always ready; write it only while the
// pipeline is empty.
// Reset empties the pipeline and loads the register reset values.
// When the receiver stalls the whole pipeline holds; the slave side is
// ready whenever the output register is empty or being taken.
module pairwise_particle_force (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [39:0]  i_cfg_data,
    // pair stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // self_x, self_y, other_x, other_y, pair_force, 4 bits zero
    input  logic [103:0] i_s_axis_tdata,
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // delta_vx, delta_vy
    output logic [39:0]  o_m_axis_tdata,
    // in_range
    output logic         o_m_axis_tuser
);
    import ppf_pkg::*;

    logic [11:0] r_width;
    logic [11:0] r_height;
    logic [19:0] r_min_d;
    logic [39:0] r_max_d2;

    logic        en;
    t_side       r_sb [0:SB_LAST];
    t_side       n_sb [0:SB_LAST];

    logic [41:0] r_sqx, r_sqy, n_sqx, n_sqy;
    logic [42:0] r_sv [0:SQ_N];
    logic [42:0] r_sr [0:SQ_N];
    logic [42:0] n_sv [0:SQ_N];
    logic [42:0] n_sr [0:SQ_N];

    logic [39:0] r_pmag, n_pmag;
    logic [42:0] r_pd, n_pd;
    logic [DIV_NW-1:0] r_num1, n_num1;
    logic [DIV_DW-1:0] r_den1, n_den1;
    logic [DIV_Q-1:0]  quo1, quox, quoy;
    logic              ovf1, ovfx, ovfy;
    logic signed [47:0] r_px, r_py, n_px, n_py;
    logic [DIV_NW-1:0] r_numx, r_numy, n_numx, n_numy;
    logic [DIV_DW-1:0] r_den2, n_den2;

    logic        r_out_valid;
    logic [19:0] r_out_vx, r_out_vy, n_out_vx, n_out_vy;
    logic        r_out_in, n_out_in;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WINDOW_WIDTH;
            r_height <= RST_WINDOW_HEIGHT;
            r_min_d  <= RST_MIN_DISTANCE;
            r_max_d2 <= RST_MAX_DIST_SQ;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WINDOW_WIDTH:  r_width  <= i_cfg_data[11:0];
                REG_WINDOW_HEIGHT: r_height <= i_cfg_data[11:0];
                REG_MIN_DISTANCE:  r_min_d  <= i_cfg_data[19:0];
                REG_MAX_DIST_SQ:   r_max_d2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless the output is held
    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // single-step toroidal wrap of one axis
    function automatic logic signed [21:0] wrap_axis(input logic signed [21:0] d,
                                                     input logic [11:0] span_px);
        logic signed [22:0] two_d;
        logic signed [22:0] span;
        two_d = {d, 1'b0};
        span  = $signed({3'b000, span_px, 8'h00});
        if (two_d > span) begin
            wrap_axis = 22'(d - span);
        end else if (two_d < -span) begin
            wrap_axis = 22'(d + span);
        end else begin
            wrap_axis = d;
        end
    endfunction

    // sideband and front stages
    always_comb begin
        logic [41:0] d2;
        logic [20:0] dq;
        logic [42:0] bitk;
        logic [42:0] trial;
        logic signed [25:0] force26;
        logic [47:0] ax, ay;

        n_sb[0].valid    = i_s_axis_tvalid;
        n_sb[0].live     = 1'b0;
        n_sb[0].sep      = 1'b0;
        n_sb[0].negx     = 1'b0;
        n_sb[0].negy     = 1'b0;
        n_sb[0].dx       = 22'($signed({2'b00, i_s_axis_tdata[59:40]})
                               - $signed({2'b00, i_s_axis_tdata[19:0]}));
        n_sb[0].dy       = 22'($signed({2'b00, i_s_axis_tdata[79:60]})
                               - $signed({2'b00, i_s_axis_tdata[39:20]}));
        n_sb[0].force_in = $signed(i_s_axis_tdata[99:80]);
        n_sb[0].d        = '0;
        for (int k = 1; k <= SB_LAST; k++) begin
            n_sb[k] = r_sb[k-1];
        end

        // wrap to nearest image
        n_sb[1].dx = wrap_axis(r_sb[0].dx, r_width);
        n_sb[1].dy = wrap_axis(r_sb[0].dy, r_height);

        // squares
        n_sqx = 42'(r_sb[1].dx * r_sb[1].dx);
        n_sqy = 42'(r_sb[1].dy * r_sb[1].dy);

        // squared distance and range test
        d2 = r_sqx + r_sqy;
        n_sb[ST_D].live = (d2 != '0) && (d2 <= {2'b00, r_max_d2});
        n_sv[0] = {1'b0, d2};
        n_sr[0] = '0;

        // integer square root, one result bit per stage
        for (int k = 0; k < SQ_N; k++) begin
            bitk  = 43'd1 << (2 * (SQ_N - 1 - k));
            trial = r_sr[k] + bitk;
            if (r_sv[k] >= trial) begin
                n_sv[k+1] = r_sv[k] - trial;
                n_sr[k+1] = (r_sr[k] >> 1) + bitk;
            end else begin
                n_sv[k+1] = r_sv[k];
                n_sr[k+1] = r_sr[k] >> 1;
            end
        end

        // separation law products
        dq = r_sr[SQ_N][20:0];
        n_sb[ST_E].d   = dq;
        n_sb[ST_E].sep = (dq < {1'b0, r_min_d});
        if (n_sb[ST_E].sep) begin
            n_pmag = 40'(r_min_d * 20'({1'b0, r_min_d} - dq));
        end else begin
            n_pmag = '0;
        end
        n_pd = 43'(({1'b0, r_min_d} + 21'd512) * ({1'b0, dq} + 22'd512));

        // rounded separation numerator
        n_num1 = DIV_NW'({r_pmag, 13'd0}) + DIV_NW'(r_pd >> 1);
        n_den1 = DIV_DW'(r_pd);

        // force select and directional products
        if (r_sb[ST_DIV1_OUT].sep) begin
            force26 = -$signed({1'b0, quo1});
        end else begin
            force26 = 26'(r_sb[ST_DIV1_OUT].force_in);
        end
        n_px = force26 * r_sb[ST_DIV1_OUT].dx;
        n_py = force26 * r_sb[ST_DIV1_OUT].dy;

        // magnitudes with rounding term
        ax = r_px[47] ? 48'(-r_px) : 48'(r_px);
        ay = r_py[47] ? 48'(-r_py) : 48'(r_py);
        n_sb[ST_H].negx = r_px[47];
        n_sb[ST_H].negy = r_py[47];
        n_numx = DIV_NW'(ax) + DIV_NW'(r_sb[ST_G].d >> 1);
        n_numy = DIV_NW'(ay) + DIV_NW'(r_sb[ST_G].d >> 1);
        n_den2 = DIV_DW'(r_sb[ST_G].d);
    end

    // saturation of one increment
    function automatic logic [19:0] sat_inc(input logic neg, input logic [24:0] q,
                                            input logic ovf);
        if (neg) begin
            sat_inc = (ovf || q > INC_NEG_MAX) ? 20'h80000 : 20'(-q);
        end else begin
            sat_inc = (ovf || q > INC_POS_MAX) ? 20'h7FFFF : q[19:0];
        end
    endfunction

    // output values
    always_comb begin
        if (r_sb[SB_LAST].live) begin
            n_out_vx = sat_inc(r_sb[SB_LAST].negx, quox, ovfx);
            n_out_vy = sat_inc(r_sb[SB_LAST].negy, quoy, ovfy);
            n_out_in = 1'b1;
        end else begin
            n_out_vx = '0;
            n_out_vy = '0;
            n_out_in = 1'b0;
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SB_LAST; k++) begin
                r_sb[k].valid <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_sb        <= n_sb;
            r_out_valid <= r_sb[SB_LAST].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx    <= n_sqx;
            r_sqy    <= n_sqy;
            r_sv     <= n_sv;
            r_sr     <= n_sr;
            r_pmag   <= n_pmag;
            r_pd     <= n_pd;
            r_num1   <= n_num1;
            r_den1   <= n_den1;
            r_px     <= n_px;
            r_py     <= n_py;
            r_numx   <= n_numx;
            r_numy   <= n_numy;
            r_den2   <= n_den2;
            r_out_vx <= n_out_vx;
            r_out_vy <= n_out_vy;
            r_out_in <= n_out_in;
        end
    end

    // separation force divider
    ppf_div u_div_sep (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num1),
        .i_den (r_den1),
        .o_quo (quo1),
        .o_ovf (ovf1)
    );

    // increment dividers
    ppf_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_numx),
        .i_den (r_den2),
        .o_quo (quox),
        .o_ovf (ovfx)
    );

    ppf_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_numy),
        .i_den (r_den2),
        .o_quo (quoy),
        .o_ovf (ovfy)
    );

    // separation quotient stays below 2^24, overflow cannot occur there
    logic unused_ovf1;
    assign unused_ovf1 = ovf1;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_vy, r_out_vx};
    assign o_m_axis_tuser  = r_out_in;

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the pairwise particle force pipeline
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ppf_pkg::*;

    localparam int PIPE_LAT   = 82;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic signed [19:0] vx;
        logic signed [19:0] vy;
        logic               in_range;
    } t_incr;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index = '0;
    logic [39:0]  i_cfg_data = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [103:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [39:0]  o_m_axis_tdata;
    logic         o_m_axis_tuser;

    pairwise_particle_force dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of the registers
    longint win_w, win_h, min_dist, max_d2;

    t_incr expected_incr[$];
    int    failures;
    int    results_seen;
    int    idle_cycles;
    int    send_idle_pct;
    int    recv_stall_pct;
    bit    hold_off;

    function automatic longint wrap_offset(longint d, longint span);
        if (2 * d > span) return d - span;
        if (2 * d < -span) return d + span;
        return d;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // divide rounding to nearest, ties away from zero
    function automatic longint round_div(longint num, longint den);
        longint mag, q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic logic signed [19:0] clamp20(longint v);
        if (v > 524287) return 20'sd524287;
        if (v < -524288) return -20'sd524288;
        return v[19:0];
    endfunction

    function automatic t_incr predict_incr(logic [103:0] pair);
        longint sx, sy, ox, oy, f, dx, dy, d2, d, m;
        t_incr r;
        sx = longint'(pair[19:0]);
        sy = longint'(pair[39:20]);
        ox = longint'(pair[59:40]);
        oy = longint'(pair[79:60]);
        f  = longint'($signed(pair[99:80]));
        dx = wrap_offset(ox - sx, win_w * 256);
        dy = wrap_offset(oy - sy, win_h * 256);
        d2 = dx * dx + dy * dy;
        r = '0;
        if (d2 == 0 || d2 > max_d2) return r;
        d = int_sqrt(d2);
        if (d < min_dist) begin
            m = min_dist;
            f = round_div(2 * m * (d - m) * 4096, (m + 512) * (d + 512));
        end
        r.vx = clamp20(round_div(f * dx, d));
        r.vy = clamp20(round_div(f * dy, d));
        r.in_range = 1'b1;
        return r;
    endfunction

    function automatic logic [103:0] pack_pair(logic [19:0] sx, logic [19:0] sy,
                                               logic [19:0] ox, logic [19:0] oy,
                                               logic [19:0] f);
        return {4'b0, f, oy, ox, sy, sx};
    endfunction

    // send one pair request and record its expected increment
    task automatic send_pair(logic [103:0] pair);
        i_cfg_valid <= 1'b0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pair;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_incr.insert(expected_incr.size(), predict_incr(pair));
    endtask

    task automatic write_reg(logic [7:0] idx, logic [39:0] val);
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_WINDOW_WIDTH:  win_w = longint'(val[11:0]);
            REG_WINDOW_HEIGHT: win_h = longint'(val[11:0]);
            REG_MIN_DISTANCE:  min_dist = longint'(val[19:0]);
            REG_MAX_DIST_SQ:   max_d2 = longint'(val);
            default: ;
        endcase
    endtask

    // drain the pipeline before a register change
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid     <= 1'b0;
        while (expected_incr.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic setup_regs(logic [11:0] w, logic [11:0] h, logic [19:0] md,
                              logic [39:0] m2);
        wait_drained();
        write_reg(REG_WINDOW_WIDTH, 40'(w));
        write_reg(REG_WINDOW_HEIGHT, 40'(h));
        write_reg(REG_MIN_DISTANCE, 40'(md));
        write_reg(REG_MAX_DIST_SQ, m2);
    endtask

    // random pair, mostly close neighbors so the cutoff passes
    task automatic send_random_pair();
        logic [19:0] sx, sy, ox, oy, f;
        sx = 20'($urandom);
        sy = 20'($urandom);
        f  = 20'($urandom);
        if ($urandom_range(3) != 0) begin
            ox = sx + 20'($signed($urandom_range(0, 2 * 30000)) - 30000);
            oy = sy + 20'($signed($urandom_range(0, 2 * 30000)) - 30000);
        end else begin
            ox = 20'($urandom);
            oy = 20'($urandom);
        end
        if ($urandom_range(15) == 0) f = $urandom_range(1) ? 20'h7ffff : 20'h80000;
        send_pair(pack_pair(sx, sy, ox, oy, f));
    endtask

    task automatic test_directed();
        setup_regs(12'd1024, 12'd768, 20'd7680, 40'd655360000);
        send_pair(pack_pair(1000, 1000, 1000, 1000, 20'h7ffff));      // coincident
        send_pair(pack_pair(0, 0, 20'hfffff, 20'hfffff, 20'h7ffff));
        send_pair(pack_pair(0, 0, 5000, 0, 20'h80000));               // separation
        send_pair(pack_pair(0, 0, 0, 1, 20'h01000));
        send_pair(pack_pair(0, 0, 20000, 0, 20'h7ffff));              // normal
        send_pair(pack_pair(0, 0, 0, 20000, 20'h80000));
        send_pair(pack_pair(0, 0, 25600, 0, 20'h01000));              // at cutoff
        send_pair(pack_pair(0, 0, 25601, 0, 20'h01000));              // just beyond
        send_pair(pack_pair(0, 0, 20'd262044, 0, 20'h01000));         // wraps
        send_pair(pack_pair(20'd262044, 0, 0, 0, 20'h01000));
        send_pair(pack_pair(0, 0, 20'd131072, 20'd98304, 20'h01000)); // half window
        // wrap disabled, huge cutoff, widest separation
        setup_regs(12'd0, 12'd0, 20'hfffff, 40'hff_ffff_ffff);
        send_pair(pack_pair(0, 0, 20'hfffff, 20'hfffff, 20'h7ffff));
        send_pair(pack_pair(20'hfffff, 20'hfffff, 0, 0, 20'h80000));
        send_pair(pack_pair(0, 0, 1, 0, 20'h7ffff));
        // smallest window and zero thresholds
        setup_regs(12'd1, 12'd1, 20'd0, 40'd0);
        send_pair(pack_pair(0, 0, 200, 0, 20'h7ffff));
        send_pair(pack_pair(0, 0, 0, 0, 20'h7ffff));
        setup_regs(12'd4095, 12'd4095, 20'd0, 40'hff_ffff_ffff);
        send_pair(pack_pair(0, 0, 20'hfffff, 1, 20'h7ffff));
        send_pair(pack_pair(5, 7, 3, 2, 20'h80000));
        wait_drained();
        write_reg(8'd4, 40'h12345);   // unused index, ignored
        send_pair(pack_pair(0, 0, 300, 400, 20'h01000));
    endtask

    task automatic test_random(int count, logic [11:0] w, logic [11:0] h,
                               logic [19:0] md, logic [39:0] m2);
        setup_regs(w, h, md, m2);
        repeat (count) send_random_pair();
    endtask

    // receiver holds off while the sender keeps offering pairs
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            repeat (300) send_random_pair();
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
    endtask

    // receiver ready pattern
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            t_incr got, want;
            got = {o_m_axis_tdata[19:0], o_m_axis_tdata[39:20], o_m_axis_tuser};
            results_seen++;
            if (expected_incr.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                failures++;
            end else begin
                want = expected_incr.pop_front();
                if (got.vx !== want.vx) begin
                    $display("%0t: delta_vx expected %0d actual %0d", $time, want.vx, got.vx);
                    failures++;
                end
                if (got.vy !== want.vy) begin
                    $display("%0t: delta_vy expected %0d actual %0d", $time, want.vy, got.vy);
                    failures++;
                end
                if (got.in_range !== want.in_range) begin
                    $display("%0t: in_range expected %0b actual %0b", $time,
                             want.in_range, got.in_range);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles with nothing accepted
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        failures = 0;
        results_seen = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        win_w = longint'(RST_WINDOW_WIDTH);
        win_h = longint'(RST_WINDOW_HEIGHT);
        min_dist = longint'(RST_MIN_DISTANCE);
        max_d2 = longint'(RST_MAX_DIST_SQ);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset values first
        repeat (20) send_random_pair();
        test_directed();
        test_random(250, 12'd1024, 12'd768, 20'd7680, 40'd655360000);
        send_idle_pct = 83;
        test_random(200, 12'd4095, 12'd4095, 20'hfffff, 40'hff_ffff_ffff);
        send_idle_pct = 0;
        recv_stall_pct = 83;
        test_random(200, 12'd200, 12'd150, 20'd2560, 40'd1 << 36);
        send_idle_pct = 16;
        recv_stall_pct = 16;
        test_random(150, 12'd1, 12'd4095, 20'd0, 40'd1 << 34);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        wait_drained();
        $display("covered %0d results over several register settings, wrap, cutoff,",
                 results_seen);
        $display("separation, saturation and a long output stall");
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
